// ===== rtl/ppkf_pkg.sv =====
// Package for the pulse-pair key-fob frame decoder.
// Holds register codes, frame layout codes, the timing window type and the window arithmetic.
// Depends on nothing; the window register module and the top level import it.
package ppkf_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int DUR_W  = 16;
  localparam int TU_W   = 12;
  localparam int IDX_W  = 5;
  localparam int TALLY_W = 7;
  localparam int FRAME_W = 64;

  // register index codes (byte address bit 2)
  localparam logic REG_LAYOUT = 1'b0;
  localparam logic REG_TUNIT  = 1'b1;

  // frame layout codes; the unused code behaves as LAY_56_PRE4
  localparam logic [1:0] LAY_56_PRE4 = 2'd0;
  localparam logic [1:0] LAY_56_PRE3 = 2'd1;
  localparam logic [1:0] LAY_64_WIN  = 2'd2;

  localparam logic [1:0]      LAYOUT_RST = LAY_56_PRE4;
  localparam logic [TU_W-1:0] TU_RST     = 12'd200;

  localparam logic [TALLY_W-1:0] LIMIT_56    = 7'd56;
  localparam logic [TALLY_W-1:0] LIMIT_64    = 7'd64;
  localparam logic [TALLY_W-1:0] MIN_BITS_56 = 7'd40;
  localparam logic [TALLY_W-1:0] MIN_BITS_64 = 7'd48;
  localparam logic [IDX_W-1:0]   MIN_PULSE_56 = 5'd18;
  localparam logic [IDX_W-1:0]   MIN_PULSE_64 = 5'd20;
  localparam logic [IDX_W-1:0]   PRE_LAST_IDX = 5'd7;
  localparam logic [IDX_W-1:0]   IDX_MAX      = 5'd31;

  // pulse-width windows derived from the time unit, all bounds inclusive
  typedef struct packed {
    logic [DUR_W-1:0] short_lo;  // 60% of one unit
    logic [DUR_W-1:0] short_hi;  // 160% of one unit
    logic [DUR_W-1:0] long_lo;   // 60% of two units
    logic [DUR_W-1:0] long_hi;   // 160% of two units
    logic [DUR_W-1:0] pre_lo;    // 60% of four units
    logic [DUR_W-1:0] pre_hi;    // 160% of four units
    logic [DUR_W-1:0] pre3;      // three units, exclusive bound
    logic [DUR_W-1:0] pre4;      // four units, exclusive bound
  } ppkf_win_t;

  // floor(x / 5) for x below 160, by reciprocal multiply
  function automatic logic [4:0] div5_small(logic [7:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'(205);
    return p[14:10];
  endfunction

  // floor(te * k / 5) from te = 5q + r
  function automatic logic [DUR_W-1:0] scale5(logic [9:0] q, logic [2:0] r,
                                              logic [5:0] k);
    logic [DUR_W-1:0] whole;
    logic [4:0]       frac;
    whole = 16'(q) * 16'(k);
    frac  = div5_small(8'(r) * 8'(k));
    return whole + 16'(frac);
  endfunction

  function automatic ppkf_win_t calc_windows(logic [TU_W-1:0] te);
    logic [27:0] prod;
    logic [9:0]  q;
    logic [2:0]  r;
    ppkf_win_t   w;
    prod = 28'(te) * 28'(52429);
    q    = prod[27:18];
    r    = 3'(te - (12'(q) << 2) - 12'(q));
    w.short_lo = scale5(q, r, 6'd3);
    w.short_hi = scale5(q, r, 6'd8);
    w.long_lo  = scale5(q, r, 6'd6);
    w.long_hi  = scale5(q, r, 6'd16);
    w.pre_lo   = scale5(q, r, 6'd12);
    w.pre_hi   = scale5(q, r, 6'd32);
    w.pre3     = 16'(te) * 16'd3;
    w.pre4     = 16'(te) << 2;
    return w;
  endfunction

endpackage

// ===== rtl/pulse_pair_keyfob_frame_decoder.sv =====
// Top level of the pulse-pair key-fob frame decoder.
// Holds the handshakes, input register, pair decoding state and result register.
// Depends on ppkf_pkg and ppkf_window_regs.
//
// Use: feed one pulse duration per item on the in_ channel (in_duration in
// microseconds, in_last on the final pulse of a capture). Pulses pair up from
// the first one of a capture; a short-long pair is bit 0, a long-short pair
// is bit 1. Only the last pulse of a capture yields an item on the out_
// channel: the valid flag, the unpacked serial, button, rolling count and
// check fields, and the number of bits decoded.
// Throughput: one item per clock while no final pulse is held. An accepted
// item is registered in the input register and decoded there; a final pulse's
// result enters the result register as it leaves the input register. All
// per-pulse work is a set of window compares and a one-bit shift between the two registers.
// Stall: while a result waits for out_ready, non-final pulses keep flowing;
// a final pulse holds in the input register until the result register frees.
// Reset (synchronous, rst_n low): capture state clears, the layout returns to
// 0 and the time unit to 200. Registers sit on an APB-style port at byte
// addresses 0 (frame_layout) and 4 (time_unit); pready is always high. A time
// unit write updates the window bounds at the same edge.
module pulse_pair_keyfob_frame_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // pulse input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ppkf_pkg::DUR_W-1:0]      in_duration,
  input  logic                            in_last,
  // decoded frame output
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_valid_res,
  output logic [31:0]                     out_serial,
  output logic [7:0]                      out_button,
  output logic [15:0]                     out_rolling_count,
  output logic [7:0]                      out_check,
  output logic [ppkf_pkg::TALLY_W-1:0]    out_bits_decoded,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppkf_pkg::CFG_AW-1:0]     paddr,
  input  logic [ppkf_pkg::CFG_DW-1:0]     pwdata,
  output logic [ppkf_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);
  import ppkf_pkg::*;

  // ---------------- configuration ----------------
  logic            cfg_wr;
  logic            reg_idx;
  logic [1:0]      layout_r;
  logic [TU_W-1:0] time_unit;
  ppkf_win_t       win;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= LAYOUT_RST;
    end else if (cfg_wr && reg_idx == REG_LAYOUT) begin
      layout_r <= pwdata[1:0];
    end
  end

  ppkf_window_regs u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cfg_wr && reg_idx == REG_TUNIT),
    .tu_wdata  (pwdata[TU_W-1:0]),
    .time_unit (time_unit),
    .win       (win)
  );

  always_comb begin
    unique case (reg_idx)
      REG_LAYOUT: prdata = {30'd0, layout_r};
      REG_TUNIT:  prdata = {20'd0, time_unit};
    endcase
  end

  // ---------------- input register ----------------
  logic             s1_v_r;
  logic [DUR_W-1:0] s1_dur_r;
  logic             s1_last_r;
  logic             out_valid_r;
  logic             out_free;
  logic             s1_go;

  // a final pulse needs the result register; other pulses always move on
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_v_r && (!s1_last_r || out_free);
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dur_r  <= in_duration;
      s1_last_r <= in_last;
    end
  end

  // ---------------- capture state ----------------
  logic [IDX_W-1:0]   idx_r,   idx_nxt,   idx_upd;
  logic               phase_r, phase_nxt;
  logic [DUR_W-1:0]   held_r,  held_nxt;
  logic               pre_r,   pre_nxt;
  logic               stop_r,  stop_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt, frame_upd;
  logic [TALLY_W-1:0] tally_r, tally_nxt, tally_upd;

  logic             p1_short, p1_long, p2_short, p2_long;
  logic             pre_hit;
  logic [TALLY_W-1:0] limit;

  function automatic logic in_win(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                  logic [DUR_W-1:0] hi);
    return (d >= lo) && (d <= hi);
  endfunction

  always_comb begin
    p1_short = in_win(held_r,   win.short_lo, win.short_hi);
    p1_long  = in_win(held_r,   win.long_lo,  win.long_hi);
    p2_short = in_win(s1_dur_r, win.short_lo, win.short_hi);
    p2_long  = in_win(s1_dur_r, win.long_lo,  win.long_hi);
    unique case (layout_r)
      LAY_64_WIN:  pre_hit = in_win(held_r, win.pre_lo, win.pre_hi) &&
                             in_win(s1_dur_r, win.pre_lo, win.pre_hi);
      LAY_56_PRE3: pre_hit = (held_r > win.pre3) && (s1_dur_r > win.pre3);
      default:     pre_hit = (held_r > win.pre4) && (s1_dur_r > win.pre4);
    endcase
    limit = (layout_r == LAY_64_WIN) ? LIMIT_64 : LIMIT_56;
  end

  // decode one pulse; the final pulse then returns the capture to its start
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    pre_nxt   = pre_r;
    stop_nxt  = stop_r;
    frame_upd = frame_r;
    tally_upd = tally_r;
    idx_upd   = idx_r;
    if (s1_go) begin
      if (!phase_r) begin
        held_nxt  = s1_dur_r;
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        if (!pre_r && idx_r <= PRE_LAST_IDX && pre_hit) begin
          pre_nxt   = 1'b1;
          stop_nxt  = 1'b0;
          frame_upd = '0;
          tally_upd = '0;
        end else if (!stop_r && tally_r < limit) begin
          priority if (p1_short && p2_long) begin
            frame_upd = {frame_r[FRAME_W-2:0], 1'b0};
            tally_upd = tally_r + 7'd1;
          end else if (p1_long && p2_short) begin
            frame_upd = {frame_r[FRAME_W-2:0], 1'b1};
            tally_upd = tally_r + 7'd1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      if (idx_r != IDX_MAX) begin
        idx_upd = idx_r + 5'd1;
      end
    end
    frame_nxt = frame_upd;
    tally_nxt = tally_upd;
    idx_nxt   = idx_upd;
    if (s1_go && s1_last_r) begin
      phase_nxt = 1'b0;
      held_nxt  = '0;
      pre_nxt   = 1'b0;
      stop_nxt  = 1'b0;
      frame_nxt = '0;
      tally_nxt = '0;
      idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= 1'b0;
      held_r  <= '0;
      pre_r   <= 1'b0;
      stop_r  <= 1'b0;
      frame_r <= '0;
      tally_r <= '0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      pre_r   <= pre_nxt;
      stop_r  <= stop_nxt;
      frame_r <= frame_nxt;
      tally_r <= tally_nxt;
    end
  end

  // ---------------- frame unpack ----------------
  logic        ok;
  logic [31:0] ser_nxt;
  logic [7:0]  btn_nxt;
  logic [15:0] cnt_nxt;
  logic [7:0]  chk_nxt;

  always_comb begin
    if (layout_r == LAY_64_WIN) begin
      ok = (idx_upd >= MIN_PULSE_64) && (tally_upd >= MIN_BITS_64);
    end else begin
      ok = (idx_upd >= MIN_PULSE_56) && (tally_upd >= MIN_BITS_56);
    end
    ser_nxt = frame_upd[31:0];
    unique case (layout_r)
      LAY_64_WIN: begin
        btn_nxt = frame_upd[55:48];
        cnt_nxt = frame_upd[47:32];
        chk_nxt = frame_upd[63:56];
      end
      LAY_56_PRE3: begin
        btn_nxt = {4'd0, frame_upd[35:32]};
        cnt_nxt = frame_upd[51:36];
        chk_nxt = {4'd0, frame_upd[55:52]};
      end
      default: begin
        btn_nxt = frame_upd[39:32];
        cnt_nxt = {4'd0, frame_upd[51:40]};
        chk_nxt = {4'd0, frame_upd[55:52]};
      end
    endcase
    // drop the fields of a capture that fails the count checks
    if (!ok) begin
      ser_nxt = '0;
      btn_nxt = '0;
      cnt_nxt = '0;
      chk_nxt = '0;
    end
  end

  // ---------------- result register ----------------
  logic               res_ok_r;
  logic [31:0]        ser_r;
  logic [7:0]         btn_r;
  logic [15:0]        cnt_r;
  logic [7:0]         chk_r;
  logic [TALLY_W-1:0] bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      res_ok_r <= ok;
      ser_r    <= ser_nxt;
      btn_r    <= btn_nxt;
      cnt_r    <= cnt_nxt;
      chk_r    <= chk_nxt;
      bits_r   <= tally_upd;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_valid_res     = res_ok_r;
  assign out_serial        = ser_r;
  assign out_button        = btn_r;
  assign out_rolling_count = cnt_r;
  assign out_check         = chk_r;
  assign out_bits_decoded  = bits_r;

endmodule

// ===== rtl/ppkf_window_regs.sv =====
// Time unit register and the pulse-width window bounds derived from it.
// Bounds are recomputed at the write so the next item sees them at once.
// Depends on ppkf_pkg.
module ppkf_window_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [ppkf_pkg::TU_W-1:0]   tu_wdata,
  output logic [ppkf_pkg::TU_W-1:0]   time_unit,
  output ppkf_pkg::ppkf_win_t         win
);
  import ppkf_pkg::*;

  logic [TU_W-1:0] tu_r;
  ppkf_win_t       win_r;
  ppkf_win_t       win_nxt;

  always_comb begin
    win_nxt = calc_windows(tu_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tu_r  <= TU_RST;
      win_r <= calc_windows(TU_RST);
    end else if (load) begin
      tu_r  <= tu_wdata;
      win_r <= win_nxt;
    end
  end

  assign time_unit = tu_r;
  assign win       = win_r;

endmodule
